[design/mlk_pkg.sv]
// Shared types, constants and the letter table of the Morse letter keyer.
package mlk_pkg;

    localparam int CHAR_W = 8;
    localparam int UNIT_W = 16;
    localparam int DUR_W  = 19;
    localparam int STEP_W = 4;

    localparam logic [UNIT_W-1:0] DOT_LENGTH_RESET = 16'd700;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_Z     = 8'h5A;

    // Bits 6..4 hold the element count, bit i is set when element i is a dash.
    typedef logic [6:0] t_code;

    localparam t_code LETTER_CODE [26] = '{
        7'h22, 7'h41, 7'h45, 7'h31, 7'h10, 7'h44, 7'h33, 7'h40, 7'h20,
        7'h4E, 7'h35, 7'h42, 7'h23, 7'h21, 7'h37, 7'h46, 7'h4B, 7'h32,
        7'h30, 7'h11, 7'h34, 7'h48, 7'h36, 7'h49, 7'h4D, 7'h43
    };

    // Classified character: what the sequencer needs to play it out.
    typedef struct packed {
        logic       is_space;
        logic [2:0] count;
        logic [3:0] dash;
    } t_desc;

    // Status of the queue as seen by its producer and consumer.
    typedef struct packed {
        logic full;
        logic valid;
    } t_q_status;

    function automatic t_desc classify(input logic [CHAR_W-1:0] ch);
        t_desc      d;
        logic [4:0] idx;
        t_code      code;
        idx        = 5'(ch - CHAR_A);
        code       = LETTER_CODE[idx];
        d.is_space = 1'b0;
        d.count    = 3'd0;
        d.dash     = 4'd0;
        if (ch == CHAR_SPACE) begin
            d.is_space = 1'b1;
        end else if (ch >= CHAR_A && ch <= CHAR_Z) begin
            d.count = code[6:4];
            d.dash  = code[3:0];
        end
        return d;
    endfunction

endpackage

[design/mlk_front.sv]
// Front stage: accepts characters and registers their classified form.
module mlk_front
    import mlk_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [CHAR_W-1:0] i_character,
    input  t_q_status         i_q_status,
    output logic              o_push,
    output t_desc             o_desc
);

    logic  r_valid;
    t_desc r_desc;

    assign o_push  = r_valid && !i_q_status.full;
    assign o_ready = !r_valid || !i_q_status.full;
    assign o_desc  = r_desc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_desc <= classify(i_character);
        end
    end

endmodule

[design/mlk_queue.sv]
// Small register queue of classified characters between front and back.
module mlk_queue
    import mlk_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_desc     i_desc,
    input  logic      i_pop,
    output t_q_status o_status,
    output t_desc     o_desc
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_desc            r_entry [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
    endfunction

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.valid = (r_count != '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && o_status.valid;
    assign o_desc         = r_entry[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= wrap_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= wrap_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= CNT_W'(r_count + 1'b1);
            end else if (do_pop && !do_push) begin
                r_count <= CNT_W'(r_count - 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_desc;
        end
    end

endmodule

[design/mlk_back.sv]
// Back stage: steps through the intervals of the queued character.
module mlk_back
    import mlk_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [UNIT_W-1:0] i_unit,
    input  t_q_status         i_q_status,
    input  t_desc             i_desc,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_light_on,
    output logic [DUR_W-1:0]  o_duration,
    output logic              o_last_interval
);

    typedef enum logic [2:0] {
        UNITS_1 = 3'b001,
        UNITS_3 = 3'b010,
        UNITS_7 = 3'b100
    } t_units;

    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid;
    logic              r_light, r_last;
    logic [DUR_W-1:0]  r_dur;

    logic             load, final_step, light, dash;
    t_units           units;
    logic [DUR_W-1:0] dur1, dur3, dur7, dur;

    assign dur1 = DUR_W'(i_unit);
    assign dur3 = DUR_W'(dur1 << 1) + dur1;
    assign dur7 = DUR_W'(dur1 << 3) - dur1;

    assign load       = i_q_status.valid && (!r_out_valid || i_ready);
    assign final_step = (r_step == {i_desc.count, 1'b0});
    assign dash       = i_desc.dash[r_step[2:1]];
    assign o_pop      = load && final_step;

    always_comb begin
        light = 1'b0;
        units = UNITS_1;
        if (final_step) begin
            units = i_desc.is_space ? UNITS_7 : UNITS_3;
        end else if (!r_step[0]) begin
            light = 1'b1;
            units = dash ? UNITS_3 : UNITS_1;
        end
        case (units)
            UNITS_1: dur = dur1;
            UNITS_3: dur = dur3;
            UNITS_7: dur = dur7;
            default: dur = dur1;
        endcase
        n_step = r_step;
        if (load) begin
            n_step = final_step ? '0 : STEP_W'(r_step + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_light <= light;
            r_dur   <= dur;
            r_last  <= final_step;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_light_on      = r_light;
    assign o_duration      = r_dur;
    assign o_last_interval = r_last;

endmodule

[design/morse_letter_keyer_unit.sv]
// Top level of the Morse letter keyer: front stage, queue and interval sequencer.
//
// Each accepted word is one ASCII character. The keyer answers with the key
// intervals that send it: for a letter A to Z, each dot or dash as an on
// interval of one or three units followed by a one-unit off interval, then a
// closing three-unit off interval; a space gives one seven-unit off interval,
// and every other code gives only the three-unit off interval. The closing
// interval carries o_last_interval. One unit is i_cfg_data ticks as last
// written through i_cfg_we (700 after reset, and a value of zero counts as
// one); write it only while the keyer is idle. The sequencer delivers one
// interval per cycle unless the output is stalled; a character gives
// 2 * elements + 1 intervals, from one for a non-letter up to nine for a
// four-element letter. The front stage classifies characters and feeds a
// queue of QUEUE_DEPTH entries. The character being played keeps its queue
// entry until its last interval is issued, so while the sequencer is busy
// or the output is stalled, up to QUEUE_DEPTH further characters are taken
// before o_ready drops, and the sequencer moves from one character to the
// next with no idle cycle. The output is registered: an accepted character
// passes the front register and a queue entry before it reaches the output.
module morse_letter_keyer_unit
    import mlk_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [UNIT_W-1:0] i_cfg_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [CHAR_W-1:0] i_character,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_light_on,
    output logic [DUR_W-1:0]  o_duration,
    output logic              o_last_interval
);

    logic [UNIT_W-1:0] r_dot_length;
    logic [UNIT_W-1:0] unit;
    t_q_status         q_status;
    t_desc             front_desc, head_desc;
    logic              push, pop;

    // Unit length register; zero is treated as one tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot_length <= DOT_LENGTH_RESET;
        end else if (i_cfg_we) begin
            r_dot_length <= i_cfg_data;
        end
    end

    assign unit = (r_dot_length == '0) ? UNIT_W'(1) : r_dot_length;

    mlk_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_character (i_character),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_desc      (front_desc)
    );

    mlk_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_desc   (front_desc),
        .i_pop    (pop),
        .o_status (q_status),
        .o_desc   (head_desc)
    );

    mlk_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_unit          (unit),
        .i_q_status      (q_status),
        .i_desc          (head_desc),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_light_on      (o_light_on),
        .o_duration      (o_duration),
        .o_last_interval (o_last_interval)
    );

    // The closing interval of a character is always key up.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_light_on && o_last_interval))
        else $error("closing interval has the key down");

    // Every interval is one, three or seven units long.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_duration == DUR_W'(unit)
                  || o_duration == DUR_W'(unit) * DUR_W'(3)
                  || o_duration == DUR_W'(unit) * DUR_W'(7)))
        else $error("interval length is not 1, 3 or 7 units");

    // A key-down interval is never the closing one and never has zero length.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_light_on) |-> !o_last_interval && o_duration != '0)
        else $error("key-down interval is malformed");

endmodule

[tb/morse_letter_keyer_unit_tb.sv]
// Self-checking testbench of the Morse letter keyer: random and directed characters, scoreboard.
`timescale 1ns / 1ps

module morse_letter_keyer_unit_tb;
    import mlk_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 5;
    // A four-element letter gives nine intervals, and each can sit through a
    // stall. About 280 words are sent in all, and the limit leaves ample room
    // for them.
    localparam int LIMIT_CYCLES = 200000;
    localparam int TAIL_CYCLES  = 4;
    localparam int PHASE_WORDS  = 52;
    localparam int PHASE_COUNT  = 5;

    // One key interval as the keyer reports it.
    typedef struct packed {
        logic             light;
        logic [DUR_W-1:0] ticks;
        logic             last;
    } t_key_interval;

    // Holds the current unit length and the key intervals still owed by the keyer.
    class interval_scoreboard;
        logic [UNIT_W-1:0] dot_length;
        t_key_interval     owed_q[$];
        int                errors;
        int                words_seen;
        int                intervals_seen;

        function new();
            dot_length     = DOT_LENGTH_RESET;
            errors         = 0;
            words_seen     = 0;
            intervals_seen = 0;
        endfunction

        function void set_dot_length(input logic [UNIT_W-1:0] value);
            dot_length = value;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // Dots are written as '.' and dashes as '-'; an empty string is not a letter.
        function string letter_pattern(input logic [CHAR_W-1:0] ch);
            case (ch)
                "A": return ".-";
                "B": return "-...";
                "C": return "-.-.";
                "D": return "-..";
                "E": return ".";
                "F": return "..-.";
                "G": return "--.";
                "H": return "....";
                "I": return "..";
                "J": return ".---";
                "K": return "-.-";
                "L": return ".-..";
                "M": return "--";
                "N": return "-.";
                "O": return "---";
                "P": return ".--.";
                "Q": return "--.-";
                "R": return ".-.";
                "S": return "...";
                "T": return "-";
                "U": return "..-";
                "V": return "...-";
                "W": return ".--";
                "X": return "-..-";
                "Y": return "-.--";
                "Z": return "--..";
                default: return "";
            endcase
        endfunction

        function void owe(input logic light, input int units, input logic last);
            t_key_interval iv;
            int            unit_ticks;
            unit_ticks = (dot_length == '0) ? 1 : int'(dot_length);
            iv.light   = light;
            iv.ticks   = DUR_W'(unit_ticks * units);
            iv.last    = last;
            owed_q.push_back(iv);
        endfunction

        // Works out every interval that one accepted character must produce.
        function void note_character(input logic [CHAR_W-1:0] ch);
            string pat;
            int    i;
            words_seen++;
            if (ch == CHAR_SPACE) begin
                owe(1'b0, 7, 1'b1);
            end else begin
                pat = letter_pattern(ch);
                for (i = 0; i < pat.len(); i++) begin
                    owe(1'b1, (pat[i] == "-") ? 3 : 1, 1'b0);
                    owe(1'b0, 1, 1'b0);
                end
                owe(1'b0, 3, 1'b1);
            end
        endfunction

        function void check_interval(input logic light, input logic [DUR_W-1:0] ticks,
                                     input logic last);
            t_key_interval exp_iv;
            intervals_seen++;
            if (owed_q.size() == 0) begin
                errors++;
                $display("%0t: interval with none expected, actual light %0d ticks %0d last %0d",
                         $time, light, ticks, last);
            end else begin
                exp_iv = owed_q.pop_front();
                if (light !== exp_iv.light) begin
                    errors++;
                    $display("%0t: light_on mismatch, expected %0d, actual %0d",
                             $time, exp_iv.light, light);
                end
                if (ticks !== exp_iv.ticks) begin
                    errors++;
                    $display("%0t: duration mismatch, expected %0d, actual %0d",
                             $time, exp_iv.ticks, ticks);
                end
                if (last !== exp_iv.last) begin
                    errors++;
                    $display("%0t: last_interval mismatch, expected %0d, actual %0d",
                             $time, exp_iv.last, last);
                end
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [UNIT_W-1:0] i_cfg_data;
    logic              i_valid;
    logic              o_ready;
    logic [CHAR_W-1:0] i_character;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic              o_light_on;
    logic [DUR_W-1:0]  o_duration;
    logic              o_last_interval;

    interval_scoreboard sb;

    // Gap and stall switches; the last phase turns both off.
    bit send_gaps;
    bit ready_stalls;
    int stall_left;
    int cycle_count;
    int settings_used;

    morse_letter_keyer_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_character     (i_character),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_light_on      (o_light_on),
        .o_duration      (o_duration),
        .o_last_interval (o_last_interval)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles with %0d intervals outstanding",
                     cycle_count, sb.pending());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Output back-pressure. When a stall starts, i_ready drops until stall_left
    // runs out. At most one assignment to i_ready happens on each edge.
    always @(posedge i_clk) begin
        if (stall_left > 1) begin
            stall_left <= stall_left - 1;
        end else if (i_rst_n && ready_stalls && $urandom_range(0, 4) == 0) begin
            i_ready    <= 1'b0;
            stall_left <= $urandom_range(1, 6);
        end else begin
            i_ready    <= 1'b1;
            stall_left <= 0;
        end
    end

    // Every interval taken at an edge is compared with the oldest one owed.
    // Values are sampled as they stood just before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_interval(o_light_on, o_duration, o_last_interval);
        end
    end

    // Offers one character and returns at the edge where it is taken. The
    // caller is always at a rising edge. With no gap, the valid that is
    // already high stays high, and the new word replaces the old one.
    task automatic send_character(input logic [CHAR_W-1:0] ch);
        if (send_gaps && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_character <= ch;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_character(ch);
    endtask

    // Drops valid and waits until the keyer has delivered everything it
    // owes. A short tail then lets the registered output settle.
    task automatic drain_keyer();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // The unit length may only change while the keyer is idle, so a write
    // always follows a drain.
    task automatic write_dot_length(input logic [UNIT_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_dot_length(value);
        settings_used++;
    endtask

    // Random traffic is weighted toward letters, which are the long
    // sequences. Spaces, codes next to the letter range, lower case letters,
    // digits and codes from the whole byte range make up the rest.
    function automatic logic [CHAR_W-1:0] pick_character();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return CHAR_A + CHAR_W'($urandom_range(0, 25));
        end else if (roll < 72) begin
            return CHAR_SPACE;
        end else if (roll < 80) begin
            case ($urandom_range(0, 3))
                0:       return CHAR_A - 8'd1;
                1:       return CHAR_Z + 8'd1;
                2:       return "a" + CHAR_W'($urandom_range(0, 25));
                default: return "0" + CHAR_W'($urandom_range(0, 9));
            endcase
        end else begin
            return CHAR_W'($urandom_range(0, 255));
        end
    endfunction

    initial begin
        logic [CHAR_W-1:0] directed_chars[$];
        logic [UNIT_W-1:0] unit_plan[PHASE_COUNT];
        int                phase;
        int                n;

        sb           = new();
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_data   = '0;
        i_valid      = 1'b0;
        i_character  = '0;
        send_gaps    = 1'b1;
        ready_stalls = 1'b1;
        stall_left   = 0;
        cycle_count  = 0;
        settings_used = 1;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words run at the reset unit length. They cover both ends of
        // the byte range, the space, the codes just outside A to Z, lower
        // case, a digit, a high code, and letters of one to four elements,
        // with dots and dashes in every position.
        directed_chars = '{8'h00, 8'hFF, CHAR_SPACE, CHAR_A - 8'd1, CHAR_Z + 8'd1,
                           "a", "z", "7", 8'h80, 8'h7F,
                           "E", "T", "A", "M", "O", "H", "J", "Q", "Y", "Z", "B"};
        foreach (directed_chars[i]) begin
            send_character(directed_chars[i]);
        end
        drain_keyer();

        // Unit lengths for the random phases: the smallest, the largest,
        // zero (which must act as one), a wide random value and a short one.
        unit_plan[0] = 16'd1;
        unit_plan[1] = 16'hFFFF;
        unit_plan[2] = 16'd0;
        unit_plan[3] = UNIT_W'($urandom_range(2, 65534));
        unit_plan[4] = UNIT_W'($urandom_range(2, 20));

        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            write_dot_length(unit_plan[phase]);
            for (n = 0; n < PHASE_WORDS; n++) begin
                // Idling is switched per stretch of 16 words, so some runs
                // go at full rate. The final phase has none.
                if (phase == PHASE_COUNT - 1) begin
                    send_gaps    = 1'b0;
                    ready_stalls = 1'b0;
                end else if (n % 16 == 0) begin
                    send_gaps    = ($urandom_range(0, 3) != 0);
                    ready_stalls = ($urandom_range(0, 3) != 0);
                end
                send_character(pick_character());
            end
            drain_keyer();
        end

        if (sb.pending() != 0) begin
            sb.errors++;
            $display("%0t: %0d expected intervals never arrived", $time, sb.pending());
        end

        $display("Sent %0d characters under %0d unit lengths, including 0, 1 and 65535.",
                 sb.words_seen, settings_used);
        $display("Checked %0d key intervals, %0d mismatches.", sb.intervals_seen, sb.errors);
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
